// File: rtl/core/multi_servo_pulse_scheduler_defines.svh
// Assertion helpers for the servo pulse scheduler.
`ifndef MULTI_SERVO_PULSE_SCHEDULER_DEFINES_SVH
`define MULTI_SERVO_PULSE_SCHEDULER_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define MSPS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("msps invariant violated");

// Same-cycle implication.
`define MSPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msps implication violated");

// Next-cycle implication.
`define MSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msps sequence violated");

`endif

// File: rtl/core/msps_pkg.sv
package msps_pkg;

   localparam logic [1:0] REQ_TIMER = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] CSR_LEAD_TICKS = 2'd0;
   localparam logic [1:0] CSR_SLOT_TICKS = 2'd1;
   localparam logic [1:0] CSR_LOW_SLOTS  = 2'd2;

   localparam logic [7:0] LEAD_TICKS_RESET = 8'd169;
   localparam logic [7:0] SLOT_TICKS_RESET = 8'd209;
   localparam logic [4:0] LOW_SLOTS_RESET  = 5'd16;

   localparam logic [4:0] PHASE_START   = 5'd0;
   localparam logic [4:0] PHASE_HIGH    = 5'd31;
   localparam logic [4:0] MAX_LOW_SLOTS = 5'd30;
   localparam logic [7:0] POS_OFF       = 8'd255;
   localparam logic [7:0] POS_MIN       = 8'd2;
   localparam logic [7:0] TAIL_RESET    = 8'd255;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] channel;
      logic [7:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] drive_enable;
      logic [7:0] drive_level;
      logic       reload_valid;
      logic [7:0] reload_ticks;
      logic [7:0] read_position;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] index;
      logic [7:0] data;
   } csr_payload_type;

endpackage

// File: rtl/core/msps_if.sv
interface msps_req_if;
   import msps_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface msps_rsp_if;
   import msps_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface msps_csr_if;
   import msps_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/multi_servo_pulse_scheduler.sv
// Servo pulse scheduler: one request transaction in, one response transaction out. Position
// writes, unknown requests and low-slot timer events pass straight to the finish state; reads
// wait in ST_RDWAIT for the position memory; a frame-start event sweeps the position memory in
// ST_LOAD; a high-window event sweeps the count memory in ST_ZERO and, when a count is active,
// again in ST_SUB. The count memory has a single read port, so it is swept once to retire
// expired channels and find the smallest count, and once more to subtract it.
// Positions and counts sit in two small synchronous memories with per-entry valid bits, so no
// clearing pass follows reset. A new request is taken as soon as the previous response has been
// staged, even while that response still waits to be taken. Drive masks cover channels 0 to 7.
// Register writes are always accepted and must only be issued while the block is idle.
`include "multi_servo_pulse_scheduler_defines.svh"

module multi_servo_pulse_scheduler #(
   parameter int NUM_CHANNELS = 8
) (
   input logic         clock,
   input logic         reset,
   msps_req_if.sink    req_ch,
   msps_rsp_if.source  rsp_ch,
   msps_csr_if.sink    csr_ch
);
   import msps_pkg::*;

   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_CHANNELS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_ZERO   = 6'b000100,
      ST_SUB    = 6'b001000,
      ST_RDWAIT = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [4:0]       phase_ff, phase_in;
   logic [7:0]       tail_ff, tail_in;
   logic [7:0]       enable_ff, enable_in;
   logic [7:0]       level_ff, level_in;
   logic [7:0]       least_ff, least_in;
   logic             res_reload_ff, res_reload_in;
   logic [7:0]       res_ticks_ff, res_ticks_in;
   logic [7:0]       res_pos_ff, res_pos_in;
   logic             rd_oor_ff, rd_oor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic [7:0] lead_ticks_ff;
   logic [7:0] slot_ticks_ff;
   logic [4:0] low_slots_ff;

   // position and count memories
   logic [7:0]              pos_mem_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] pos_vld_ff;
   logic [7:0]              pos_rdata_ff;
   logic                    pos_rvld_ff;
   logic                    pos_we, pos_re;
   logic [CH_W-1:0]         pos_waddr, pos_raddr;
   logic [7:0]              pos_wdata;

   logic [7:0]              tck_mem_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] tck_vld_ff;
   logic [7:0]              tck_rdata_ff;
   logic                    tck_rvld_ff;
   logic                    tck_we, tck_re;
   logic [CH_W-1:0]         tck_waddr, tck_raddr;
   logic [7:0]              tck_wdata;

   logic             req_fire;
   logic             ch_ok;
   logic [CH_W-1:0]  ch_idx;
   logic [CNT_W-1:0] cnt_prev;
   logic [CH_W-1:0]  scan_idx, proc_idx;
   logic [7:0]       proc_bit;
   logic [7:0]       pos_val, tck_val, tck_ret, least_new;
   logic [4:0]       low_phase;
   logic             sub_write;
   logic             load_done;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;
   assign csr_ch.ready   = 1'b1;

   assign ch_ok     = (32'(req_ch.payload.channel) < NUM_CHANNELS);
   assign ch_idx    = CH_W'(req_ch.payload.channel);
   assign cnt_prev  = cnt_ff - 1'b1;
   assign scan_idx  = cnt_ff[CH_W-1:0];
   assign proc_idx  = cnt_prev[CH_W-1:0];
   assign proc_bit  = 8'(1) << cnt_prev;
   assign pos_val   = pos_rvld_ff ? pos_rdata_ff : POS_OFF;
   assign tck_val   = tck_rvld_ff ? tck_rdata_ff : POS_OFF;
   assign tck_ret   = (tck_val == 8'd0) ? POS_OFF : tck_val;
   assign least_new = (tck_ret < least_ff) ? tck_ret : least_ff;
   assign low_phase = (low_slots_ff > MAX_LOW_SLOTS) ? MAX_LOW_SLOTS : low_slots_ff;
   assign sub_write = (state_ff == ST_SUB) && tck_we;
   assign load_done = (state_ff == ST_LOAD) && (cnt_ff == LAST_CNT);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      phase_in       = phase_ff;
      tail_in        = tail_ff;
      enable_in      = enable_ff;
      level_in       = level_ff;
      least_in       = least_ff;
      res_reload_in  = res_reload_ff;
      res_ticks_in   = res_ticks_ff;
      res_pos_in     = res_pos_ff;
      rd_oor_in      = rd_oor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_payload_in = rsp_payload_ff;
      pos_we         = 1'b0;
      pos_waddr      = ch_idx;
      pos_wdata      = (req_ch.payload.position < POS_MIN) ? POS_MIN : req_ch.payload.position;
      pos_re         = 1'b0;
      pos_raddr      = ch_idx;
      tck_we         = 1'b0;
      tck_waddr      = proc_idx;
      tck_wdata      = POS_OFF;
      tck_re         = 1'b0;
      tck_raddr      = scan_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_reload_in = 1'b0;
               res_ticks_in  = 8'd0;
               res_pos_in    = 8'd0;
               cnt_in        = '0;
               state_in      = ST_FINISH;
               case (req_ch.payload.req_type)
                  REQ_TIMER: begin
                     res_reload_in = 1'b1;
                     if (phase_ff == PHASE_START) begin
                        state_in = ST_LOAD;
                     end else if (phase_ff == PHASE_HIGH) begin
                        least_in = POS_OFF;
                        state_in = ST_ZERO;
                     end else begin
                        phase_in     = phase_ff - 5'd1;
                        res_ticks_in = slot_ticks_ff;
                     end
                  end
                  REQ_WRITE: begin
                     pos_we = ch_ok;
                  end
                  REQ_READ: begin
                     pos_re    = ch_ok;
                     rd_oor_in = !ch_ok;
                     state_in  = ST_RDWAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (cnt_ff != LAST_CNT) begin
               pos_re    = 1'b1;
               pos_raddr = scan_idx;
            end
            if (cnt_ff != '0) begin
               tck_we    = 1'b1;
               tck_wdata = pos_val;
               if (pos_val == POS_OFF) begin
                  enable_in = enable_ff & ~proc_bit;
                  level_in  = level_ff & ~proc_bit;
               end else begin
                  enable_in = enable_ff | proc_bit;
                  level_in  = level_ff | proc_bit;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               tail_in      = TAIL_RESET;
               phase_in     = PHASE_HIGH;
               res_ticks_in = lead_ticks_ff;
               state_in     = ST_FINISH;
            end
         end
         ST_ZERO: begin
            tck_re = (cnt_ff != LAST_CNT);
            if (cnt_ff != '0) begin
               least_in = least_new;
               if (tck_val == 8'd0) begin
                  tck_we   = 1'b1;
                  level_in = level_ff & ~proc_bit;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               cnt_in = '0;
               if (least_new != POS_OFF) begin
                  state_in = ST_SUB;
               end else begin
                  phase_in     = low_phase;
                  res_ticks_in = tail_ff;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_SUB: begin
            tck_re = (cnt_ff != LAST_CNT);
            if ((cnt_ff != '0) && (tck_val != POS_OFF)) begin
               tck_we    = 1'b1;
               tck_wdata = tck_val - least_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               tail_in      = tail_ff - least_ff;
               res_ticks_in = least_ff;
               state_in     = ST_FINISH;
            end
         end
         ST_RDWAIT: begin
            res_pos_in = rd_oor_ff ? POS_OFF : pos_val;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.drive_enable  = enable_ff;
               rsp_payload_in.drive_level   = level_ff;
               rsp_payload_in.reload_valid  = res_reload_ff;
               rsp_payload_in.reload_ticks  = res_ticks_ff;
               rsp_payload_in.read_position = res_pos_ff;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= PHASE_HIGH;
         tail_ff      <= TAIL_RESET;
         enable_ff    <= 8'd0;
         level_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
         pos_vld_ff   <= '0;
         tck_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         tail_ff      <= tail_in;
         enable_ff    <= enable_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pos_we) begin
            pos_vld_ff[pos_waddr] <= 1'b1;
         end
         if (tck_we) begin
            tck_vld_ff[tck_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      least_ff       <= least_in;
      res_reload_ff  <= res_reload_in;
      res_ticks_ff   <= res_ticks_in;
      res_pos_ff     <= res_pos_in;
      rd_oor_ff      <= rd_oor_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem_ff[pos_waddr] <= pos_wdata;
      end
      if (pos_re) begin
         pos_rdata_ff <= pos_mem_ff[pos_raddr];
         pos_rvld_ff  <= pos_vld_ff[pos_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tck_we) begin
         tck_mem_ff[tck_waddr] <= tck_wdata;
      end
      if (tck_re) begin
         tck_rdata_ff <= tck_mem_ff[tck_raddr];
         tck_rvld_ff  <= tck_vld_ff[tck_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ticks_ff <= LEAD_TICKS_RESET;
         slot_ticks_ff <= SLOT_TICKS_RESET;
         low_slots_ff  <= LOW_SLOTS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.payload.index)
            CSR_LEAD_TICKS: lead_ticks_ff <= csr_ch.payload.data;
            CSR_SLOT_TICKS: slot_ticks_ff <= csr_ch.payload.data;
            CSR_LOW_SLOTS:  low_slots_ff  <= csr_ch.payload.data[4:0];
            default: begin
            end
         endcase
      end
   end

   `MSPS_ASSERT_ALWAYS(a_level_within_enable, clock, reset, (level_ff & ~enable_ff) == 8'd0)
   `MSPS_ASSERT_IMPL(a_sub_has_active, clock, reset, state_ff == ST_SUB, least_ff != POS_OFF)
   `MSPS_ASSERT_IMPL(a_sub_stays_active, clock, reset, sub_write, tck_wdata != POS_OFF)
   `MSPS_ASSERT_IMPL(a_pos_clamped, clock, reset, pos_we, pos_wdata >= POS_MIN)
   `MSPS_ASSERT_NEXT(a_load_enters_high, clock, reset, load_done, phase_ff == PHASE_HIGH)

endmodule

// File: tb/msps_schedule_monitor.sv
module msps_schedule_monitor (
   input  logic clock,
   input  logic reset,
   msps_req_if  req_ch,
   msps_rsp_if  rsp_ch,
   msps_csr_if  csr_ch,
   output int   pending,
   output int   failures
);
   timeunit 1ns;
   timeprecision 1ps;

   import msps_pkg::*;

   localparam int CHANNELS = 8;

   logic [7:0] lead_ticks;
   logic [7:0] slot_ticks;
   logic [4:0] low_slots;

   logic [4:0] frame_phase;
   logic [7:0] tail_budget;
   logic [7:0] position_mem [CHANNELS];
   logic [7:0] ticks_left [CHANNELS];
   logic [7:0] enable_mask;
   logic [7:0] level_mask;

   rsp_payload_type expected_rsp_q [$];

   function automatic rsp_payload_type predict_response(input req_payload_type req);
      rsp_payload_type rsp;
      logic [7:0] least;
      rsp = '0;
      case (req.req_type)
         REQ_TIMER: begin
            rsp.reload_valid = 1'b1;
            if (frame_phase == PHASE_START) begin
               for (int j = 0; j < CHANNELS; j++) begin
                  ticks_left[j] = position_mem[j];
                  enable_mask[j] = (position_mem[j] != POS_OFF);
                  level_mask[j] = (position_mem[j] != POS_OFF);
               end
               tail_budget = TAIL_RESET;
               frame_phase = PHASE_HIGH;
               rsp.reload_ticks = lead_ticks;
            end else if (frame_phase == PHASE_HIGH) begin
               least = POS_OFF;
               for (int j = 0; j < CHANNELS; j++) begin
                  if (ticks_left[j] == 8'd0) begin
                     level_mask[j] = 1'b0;
                     ticks_left[j] = POS_OFF;
                  end
                  if (ticks_left[j] < least) least = ticks_left[j];
               end
               if (least != POS_OFF) begin
                  for (int j = 0; j < CHANNELS; j++)
                     if (ticks_left[j] != POS_OFF) ticks_left[j] = ticks_left[j] - least;
                  tail_budget = tail_budget - least;
                  rsp.reload_ticks = least;
               end else begin
                  // low slot count saturates below the high-window code
                  frame_phase = (low_slots > MAX_LOW_SLOTS) ? MAX_LOW_SLOTS : low_slots;
                  rsp.reload_ticks = tail_budget;
               end
            end else begin
               frame_phase = frame_phase - 5'd1;
               rsp.reload_ticks = slot_ticks;
            end
         end
         REQ_WRITE: position_mem[req.channel] = (req.position < POS_MIN) ? POS_MIN : req.position;
         REQ_READ: rsp.read_position = position_mem[req.channel];
         default: ;
      endcase
      rsp.drive_enable = enable_mask;
      rsp.drive_level = level_mask;
      return rsp;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         lead_ticks = LEAD_TICKS_RESET;
         slot_ticks = SLOT_TICKS_RESET;
         low_slots = LOW_SLOTS_RESET;
         frame_phase = PHASE_HIGH;
         tail_budget = TAIL_RESET;
         for (int j = 0; j < CHANNELS; j++) begin
            position_mem[j] = POS_OFF;
            ticks_left[j] = POS_OFF;
         end
         enable_mask = '0;
         level_mask = '0;
         expected_rsp_q.delete();
         failures = 0;
      end else begin
         // compare before pushing: a response never belongs to a same-edge request
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsp_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display({"%0t: response transaction with none expected:",
                            " en=%h lvl=%h rv=%b rt=%0d rp=%0d"},
                     $time, got.drive_enable, got.drive_level, got.reload_valid,
                     got.reload_ticks, got.read_position);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.drive_enable !== want.drive_enable ||
                   got.drive_level !== want.drive_level ||
                   got.reload_valid !== want.reload_valid ||
                   got.reload_ticks !== want.reload_ticks ||
                   got.read_position !== want.read_position) begin
                  failures++;
                  if (failures <= 10)
                     $display({"%0t: response mismatch:",
                               " expected en=%h lvl=%h rv=%b rt=%0d rp=%0d,",
                               " actual en=%h lvl=%h rv=%b rt=%0d rp=%0d"},
                        $time, want.drive_enable, want.drive_level, want.reload_valid,
                        want.reload_ticks, want.read_position, got.drive_enable,
                        got.drive_level, got.reload_valid, got.reload_ticks, got.read_position);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.payload.index)
               CSR_LEAD_TICKS: lead_ticks = csr_ch.payload.data;
               CSR_SLOT_TICKS: slot_ticks = csr_ch.payload.data;
               CSR_LOW_SLOTS:  low_slots = csr_ch.payload.data[4:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_rsp_q.push_back(predict_response(req_ch.payload));
      end
      pending = expected_rsp_q.size();
   end

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msps_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 133;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic quiet = 1'b0;
   logic hold_toggle = 1'b0;
   int pending;
   int failures;
   int cycle_count = 0;

   msps_req_if req_ch ();
   msps_rsp_if rsp_ch ();
   msps_csr_if csr_ch ();

   multi_servo_pulse_scheduler #(.NUM_CHANNELS(8)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   msps_schedule_monitor monitor (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_ch   (csr_ch),
      .pending  (pending),
      .failures (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multi_servo_pulse_scheduler: mismatch");
         $finish;
      end
   end

   // response side: random stalls, a long hold-off on request, none while quiet
   initial begin : rsp_side
      int hold_left;
      logic seen_toggle;
      hold_left = 0;
      seen_toggle = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 6);
         end
      end
   end

   task automatic send_req(input logic [1:0] kind, input logic [2:0] ch, input logic [7:0] pos);
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{req_type: kind, channel: ch, position: pos};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= '{index: index, data: data};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] lead, input logic [7:0] slot, input logic [4:0] lows);
      write_csr(CSR_LEAD_TICKS, lead);
      write_csr(CSR_SLOT_TICKS, slot);
      write_csr(CSR_LOW_SLOTS, {3'($urandom), lows});
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [1:0] kind;
      logic [7:0] pos;
      logic calm;
      int pick;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // clamping, disabled and never-written channels, ties between channels
      send_req(REQ_WRITE, 3'd0, 8'd0);
      send_req(REQ_WRITE, 3'd1, 8'd1);
      send_req(REQ_WRITE, 3'd2, 8'd2);
      send_req(REQ_WRITE, 3'd3, 8'd254);
      send_req(REQ_WRITE, 3'd4, 8'd2);
      send_req(REQ_WRITE, 3'd5, 8'd128);
      send_req(REQ_WRITE, 3'd7, 8'd255);
      send_req(REQ_READ, 3'd0, 8'hFF);
      send_req(REQ_READ, 3'd3, 8'h00);
      send_req(REQ_READ, 3'd6, 8'h00);
      send_req(REQ_READ, 3'd7, 8'hA5);
      send_req(REQ_UNKNOWN, 3'd7, 8'hFF);
      wait_drained();
      // no low slots: one full frame and the start of the next
      configure(LEAD_TICKS_RESET, SLOT_TICKS_RESET, 5'd0);
      repeat (8) send_req(REQ_TIMER, 3'($urandom), 8'($urandom));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: configure(LEAD_TICKS_RESET, SLOT_TICKS_RESET, LOW_SLOTS_RESET);
            1: configure(8'd0, 8'd0, 5'd0);
            2: configure(8'd255, 8'd255, 5'd31);
            3: configure(8'd1, 8'd1, 5'd1);
            default: begin
               write_csr(CSR_SPARE, 8'($urandom));
               configure(8'($urandom), 8'($urandom), 5'($urandom));
            end
         endcase
         calm = (ph == 3);
         quiet <= calm;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == 20) hold_toggle <= ~hold_toggle;
            if (!calm && $urandom_range(99) < 6) begin
               req_ch.valid <= 1'b0;
               repeat ($urandom_range(4, 1)) @(negedge clock);
            end
            if ($urandom_range(199) == 0) wait_drained();
            pick = $urandom_range(99);
            if (pick < 55) kind = REQ_TIMER;
            else if (pick < 80) kind = REQ_WRITE;
            else if (pick < 95) kind = REQ_READ;
            else kind = REQ_UNKNOWN;
            pick = $urandom_range(9);
            if (pick < 3) pos = 8'($urandom_range(3));
            else if (pick < 4) pos = 8'($urandom_range(255, 252));
            else if (pick < 7) pos = 8'($urandom_range(40, 2));
            else pos = 8'($urandom);
            send_req(kind, 3'($urandom), pos);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("multi_servo_pulse_scheduler: match");
      else
         $display("multi_servo_pulse_scheduler: mismatch");
      $finish;
   end

endmodule
